>>> rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the serial instruction transfer core.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int MAX_BYTES_DEF = 8;
  localparam int ADDR_W        = 11;
  localparam int COUNT_W       = 4;
  localparam int DATA_W        = 64;
  localparam int HDR_W         = 16;
  localparam int BITS_W        = 7;
  localparam int COUNT_POS     = 13;
  localparam int READ_POS      = 15;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic               is_read;
    logic [ADDR_W-1:0]  reg_address;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  write_data;
    logic               sdio_in;
  } sit_item_t;

  typedef struct packed {
    logic              chip_select_n;
    logic              clock_pulse;
    logic              sdio_out;
    logic              sdio_drive;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
  } sit_result_t;

endpackage

>>> rtl/core/sit_in_stage.sv
// ----------------------------------------------------------------------------
// sit_in_stage
// Input register: holds one item until the transfer engine takes it.
// ----------------------------------------------------------------------------
module sit_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sit_pkg::sit_item_t item_in,
  output logic               held_valid,
  input  logic               advance,
  output sit_pkg::sit_item_t item_held
);

  logic               valid_q;
  sit_pkg::sit_item_t item_q;

  assign in_ready   = !valid_q || advance;
  assign held_valid = valid_q;
  assign item_held  = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

endmodule

>>> rtl/core/sit_engine.sv
// ----------------------------------------------------------------------------
// sit_engine
// Transfer state and per-item logic: header build, bit-slot shifting and
// read-data assembly.
// ----------------------------------------------------------------------------
module sit_engine #(
  parameter int MAX_BYTES = sit_pkg::MAX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  sit_pkg::sit_item_t   item,
  output sit_pkg::sit_result_t result
);

  logic                          busy;
  logic                          busy_next;
  logic                          read_mode;
  logic                          read_mode_next;
  logic [sit_pkg::HDR_W-1:0]     header_shift;
  logic [sit_pkg::HDR_W-1:0]     header_shift_next;
  logic [sit_pkg::DATA_W-1:0]    data_shift;
  logic [sit_pkg::DATA_W-1:0]    data_shift_next;
  logic [sit_pkg::DATA_W-1:0]    read_accumulator;
  logic [sit_pkg::DATA_W-1:0]    read_accumulator_next;
  logic [sit_pkg::BITS_W-1:0]    bits_left;
  logic [sit_pkg::BITS_W-1:0]    bits_left_next;
  logic [sit_pkg::BITS_W-1:0]    data_bits_total;
  logic [sit_pkg::BITS_W-1:0]    data_bits_total_next;

  logic [sit_pkg::COUNT_W-1:0]   count;
  logic [1:0]                    len_field;
  logic [sit_pkg::BITS_W-1:0]    start_bits;

  assign count = (item.byte_count > sit_pkg::COUNT_W'(MAX_BYTES))
               ? sit_pkg::COUNT_W'(MAX_BYTES) : item.byte_count;
  assign len_field = (count > 4'd3) ? 2'd3 : 2'(count - 4'd1);
  assign start_bits = {count, 3'b000};

  always_comb begin
    busy_next             = busy;
    read_mode_next        = read_mode;
    header_shift_next     = header_shift;
    data_shift_next       = data_shift;
    read_accumulator_next = read_accumulator;
    bits_left_next        = bits_left;
    data_bits_total_next  = data_bits_total;

    result.chip_select_n = 1'b1;
    result.clock_pulse   = 1'b0;
    result.sdio_out      = 1'b0;
    result.sdio_drive    = 1'b1;
    result.done_res      = 1'b0;
    result.read_data     = '0;

    if (item.req_type == sit_pkg::REQ_START) begin
      if (busy) begin
        result.chip_select_n = 1'b0;
        result.sdio_drive    = !read_mode;
      end else if (count == '0) begin
        result.done_res = 1'b1;
      end else begin
        read_mode_next = item.is_read;
        header_shift_next = {item.is_read, len_field, 2'b00, item.reg_address};
        data_bits_total_next = start_bits;
        // left-justify the low count bytes
        data_shift_next = item.write_data << (7'd64 - start_bits);
        read_accumulator_next = '0;
        bits_left_next = 7'(sit_pkg::HDR_W) + start_bits;
        busy_next = 1'b1;
        result.chip_select_n = 1'b0;
      end
    end else if (busy) begin
      result.chip_select_n = 1'b0;
      result.clock_pulse   = 1'b1;
      if (bits_left > data_bits_total) begin
        result.sdio_out   = header_shift[sit_pkg::HDR_W-1];
        header_shift_next = {header_shift[sit_pkg::HDR_W-2:0], 1'b0};
      end else if (read_mode) begin
        result.sdio_drive     = 1'b0;
        read_accumulator_next = {read_accumulator[sit_pkg::DATA_W-2:0], item.sdio_in};
      end else begin
        result.sdio_out = data_shift[sit_pkg::DATA_W-1];
        data_shift_next = {data_shift[sit_pkg::DATA_W-2:0], 1'b0};
      end
      bits_left_next = bits_left - 7'd1;
      if (bits_left_next == '0) begin
        result.done_res  = 1'b1;
        result.read_data = read_mode ? read_accumulator_next : '0;
        busy_next        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      read_mode <= 1'b0;
    end else if (advance) begin
      busy      <= busy_next;
      read_mode <= read_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      header_shift     <= header_shift_next;
      data_shift       <= data_shift_next;
      read_accumulator <= read_accumulator_next;
      bits_left        <= bits_left_next;
      data_bits_total  <= data_bits_total_next;
    end
  end

endmodule

>>> rtl/core/sit_out_stage.sv
// ----------------------------------------------------------------------------
// sit_out_stage
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module sit_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sit_pkg::sit_result_t result_in,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sit_pkg::sit_result_t result_out
);

  logic                 valid_q;
  sit_pkg::sit_result_t result_q;

  assign room       = !valid_q || out_ready;
  assign out_valid  = valid_q;
  assign result_out = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (room) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

>>> rtl/core/spi_instruction_transfer_core.sv
// ----------------------------------------------------------------------------
// spi_instruction_transfer_core
// Three-wire serial master for register access: 16-bit instruction header
// followed by up to MAX_BYTES data bytes, written or read one bit per tick.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | req_type is_read reg_address byte_count
//          |                      | write_data sdio_in
//  out     | out_valid/ out_ready | chip_select_n clock_pulse sdio_out
//          |                      | sdio_drive done_res read_data
//
// One item per clock while out is not stalled; each item gives one result,
// passing through the input register and then the result register.
// The transfer state advances only when the held item moves into the
// result register, so a stall on out holds everything in place.
// rst is synchronous and clears the valid flags and the busy/read state.
// ----------------------------------------------------------------------------
module spi_instruction_transfer_core #(
  parameter int MAX_BYTES = sit_pkg::MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic                           is_read,
  input  logic [sit_pkg::ADDR_W-1:0]     reg_address,
  input  logic [sit_pkg::COUNT_W-1:0]    byte_count,
  input  logic [sit_pkg::DATA_W-1:0]     write_data,
  input  logic                           sdio_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           chip_select_n,
  output logic                           clock_pulse,
  output logic                           sdio_out,
  output logic                           sdio_drive,
  output logic                           done_res,
  output logic [sit_pkg::DATA_W-1:0]     read_data
);

  sit_pkg::sit_item_t   item_in;
  sit_pkg::sit_item_t   item_held;
  sit_pkg::sit_result_t result_next;
  sit_pkg::sit_result_t result_out;
  logic                 held_valid;
  logic                 room;
  logic                 advance;

  assign item_in.req_type    = req_type;
  assign item_in.is_read     = is_read;
  assign item_in.reg_address = reg_address;
  assign item_in.byte_count  = byte_count;
  assign item_in.write_data  = write_data;
  assign item_in.sdio_in     = sdio_in;

  assign advance = held_valid && room;

  sit_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .held_valid (held_valid),
    .advance    (advance),
    .item_held  (item_held)
  );

  sit_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_held),
    .result  (result_next)
  );

  sit_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (result_next),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_out)
  );

  assign chip_select_n = result_out.chip_select_n;
  assign clock_pulse   = result_out.clock_pulse;
  assign sdio_out      = result_out.sdio_out;
  assign sdio_drive    = result_out.sdio_drive;
  assign done_res      = result_out.done_res;
  assign read_data     = result_out.read_data;

endmodule

>>> test/spi_instruction_transfer_core_test.sv
// ----------------------------------------------------------------------------
// spi_instruction_transfer_core_test
// Self-checking bench for the serial instruction transfer core. A directed
// table covers idle ticks, zero and oversized byte counts, starts while busy
// and the final bit slot. Random read and write transfers with random
// handshake gaps follow. Each result is checked against its table value or a bit-slot predictor.
// ----------------------------------------------------------------------------
module spi_instruction_transfer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES    = sit_pkg::MAX_BYTES_DEF;
  localparam int RANDOM_ITEMS = 80;
  localparam int QUIET_LIMIT  = 4000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        req_type = sit_pkg::REQ_TICK;
  logic                        is_read = 1'b0;
  logic [sit_pkg::ADDR_W-1:0]  reg_address = '0;
  logic [sit_pkg::COUNT_W-1:0] byte_count = '0;
  logic [sit_pkg::DATA_W-1:0]  write_data = '0;
  logic                        sdio_in = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        chip_select_n;
  logic                        clock_pulse;
  logic                        sdio_out;
  logic                        sdio_drive;
  logic                        done_res;
  logic [sit_pkg::DATA_W-1:0]  read_data;

  spi_instruction_transfer_core #(
    .MAX_BYTES(MAX_BYTES)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .is_read(is_read), .reg_address(reg_address),
    .byte_count(byte_count), .write_data(write_data), .sdio_in(sdio_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .chip_select_n(chip_select_n), .clock_pulse(clock_pulse),
    .sdio_out(sdio_out), .sdio_drive(sdio_drive), .done_res(done_res),
    .read_data(read_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the transfer state
  logic                       xfer_busy = 1'b0;
  logic                       xfer_read = 1'b0;
  logic [sit_pkg::HDR_W-1:0]  hdr_sr = '0;
  logic [sit_pkg::DATA_W-1:0] data_sr = '0;
  logic [sit_pkg::DATA_W-1:0] rd_acc = '0;
  logic [sit_pkg::BITS_W-1:0] slots_left = '0;
  logic [sit_pkg::BITS_W-1:0] data_slots = '0;

  sit_pkg::sit_result_t slot_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  typedef struct {
    sit_pkg::sit_item_t   item;
    int unsigned          reps;
    bit                   typed;
    sit_pkg::sit_result_t want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic sit_pkg::sit_result_t mk_res(logic cs, logic pulse, logic sd,
                                                  logic drv, logic done,
                                                  logic [sit_pkg::DATA_W-1:0] rd);
    sit_pkg::sit_result_t r;
    r.chip_select_n = cs;
    r.clock_pulse   = pulse;
    r.sdio_out      = sd;
    r.sdio_drive    = drv;
    r.done_res      = done;
    r.read_data     = rd;
    return r;
  endfunction

  function automatic sit_pkg::sit_item_t mk_start(logic rd,
                                                  logic [sit_pkg::ADDR_W-1:0] addr,
                                                  logic [sit_pkg::COUNT_W-1:0] cnt,
                                                  logic [sit_pkg::DATA_W-1:0] wd);
    sit_pkg::sit_item_t it;
    it.req_type    = sit_pkg::REQ_START;
    it.is_read     = rd;
    it.reg_address = addr;
    it.byte_count  = cnt;
    it.write_data  = wd;
    it.sdio_in     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // tick with random content in the fields a tick ignores
  function automatic sit_pkg::sit_item_t mk_tick(logic line);
    sit_pkg::sit_item_t it;
    it = mk_start(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                  4'($urandom_range(0, 15)), {$urandom, $urandom});
    it.req_type = sit_pkg::REQ_TICK;
    it.sdio_in  = line;
    return it;
  endfunction

  function automatic sit_pkg::sit_item_t rand_start();
    int unsigned pick;
    logic [sit_pkg::COUNT_W-1:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 5)       cnt = '0;
    else if (pick < 55) cnt = 4'($urandom_range(1, 2));
    else if (pick < 88) cnt = 4'($urandom_range(3, 8));
    else                cnt = 4'($urandom_range(9, 15));
    return mk_start(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)), cnt,
                    {$urandom, $urandom});
  endfunction

  function automatic sit_pkg::sit_result_t predict_slot_result(sit_pkg::sit_item_t it);
    sit_pkg::sit_result_t r;
    int unsigned cnt;
    r = mk_res(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    if (it.req_type == sit_pkg::REQ_START) begin
      if (xfer_busy) begin
        r.chip_select_n = 1'b0;
        r.sdio_drive    = ~xfer_read;
        return r;
      end
      cnt = it.byte_count;
      if (cnt > MAX_BYTES) cnt = MAX_BYTES;
      if (cnt == 0) begin
        r.done_res = 1'b1;
        return r;
      end
      xfer_read = it.is_read;
      hdr_sr = '0;
      hdr_sr[sit_pkg::READ_POS] = it.is_read;
      hdr_sr[sit_pkg::COUNT_POS +: 2] = (cnt > 3) ? 2'd3 : 2'(cnt - 1);
      hdr_sr[sit_pkg::ADDR_W-1:0] = it.reg_address;
      data_slots = sit_pkg::BITS_W'(cnt * 8);
      if (cnt * 8 >= sit_pkg::DATA_W) data_sr = it.write_data;
      else data_sr = it.write_data << (sit_pkg::DATA_W - cnt * 8);
      rd_acc = '0;
      slots_left = sit_pkg::BITS_W'(sit_pkg::HDR_W + cnt * 8);
      xfer_busy = 1'b1;
      r.chip_select_n = 1'b0;
      return r;
    end
    if (!xfer_busy) return r;
    r.chip_select_n = 1'b0;
    r.clock_pulse   = 1'b1;
    if (slots_left > data_slots) begin
      r.sdio_out = hdr_sr[sit_pkg::HDR_W-1];
      hdr_sr = hdr_sr << 1;
    end else if (xfer_read) begin
      r.sdio_drive = 1'b0;
      rd_acc = {rd_acc[sit_pkg::DATA_W-2:0], it.sdio_in};
    end else begin
      r.sdio_out = data_sr[sit_pkg::DATA_W-1];
      data_sr = data_sr << 1;
    end
    slots_left = slots_left - 1'b1;
    if (slots_left == 0) begin
      r.done_res  = 1'b1;
      r.read_data = xfer_read ? rd_acc : '0;
      xfer_busy   = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_row(sit_pkg::sit_item_t it, int unsigned reps, bit typed,
                                  sit_pkg::sit_result_t want);
    stim_row_t row;
    row.item  = it;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  // valid is only lowered when a gap is taken, so back-to-back items keep it high
  task automatic send_item(sit_pkg::sit_item_t it, bit typed, sit_pkg::sit_result_t want);
    sit_pkg::sit_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= it.req_type;
    is_read     <= it.is_read;
    reg_address <= it.reg_address;
    byte_count  <= it.byte_count;
    write_data  <= it.write_data;
    sdio_in     <= it.sdio_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_slot_result(it);
    slot_results_due.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic run_transfer();
    sit_pkg::sit_item_t st;
    int unsigned cnt;
    int unsigned slots;
    st = rand_start();
    send_item(st, 1'b0, '0);
    cnt = st.byte_count;
    if (cnt > MAX_BYTES) cnt = MAX_BYTES;
    slots = (cnt == 0) ? 0 : sit_pkg::HDR_W + cnt * 8;
    for (int unsigned i = 0; i < slots; i++) begin
      // stray start in the middle of a transfer
      if ($urandom_range(0, 99) < 3) send_item(rand_start(), 1'b0, '0);
      send_item(mk_tick(1'($urandom_range(0, 1))), 1'b0, '0);
    end
    if ($urandom_range(0, 99) < 20) send_item(mk_tick(1'($urandom_range(0, 1))), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sit_pkg::sit_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (slot_results_due.size() == 0) begin
        $error("result item with nothing expected");
        mismatch_count++;
      end else begin
        exp_res = slot_results_due.pop_front();
        if (chip_select_n !== exp_res.chip_select_n) begin
          $error("chip_select_n: expected %0h, got %0h", exp_res.chip_select_n, chip_select_n);
          mismatch_count++;
        end
        if (clock_pulse !== exp_res.clock_pulse) begin
          $error("clock_pulse: expected %0h, got %0h", exp_res.clock_pulse, clock_pulse);
          mismatch_count++;
        end
        if (sdio_out !== exp_res.sdio_out) begin
          $error("sdio_out: expected %0h, got %0h", exp_res.sdio_out, sdio_out);
          mismatch_count++;
        end
        if (sdio_drive !== exp_res.sdio_drive) begin
          $error("sdio_drive: expected %0h, got %0h", exp_res.sdio_drive, sdio_drive);
          mismatch_count++;
        end
        if (done_res !== exp_res.done_res) begin
          $error("done_res: expected %0h, got %0h", exp_res.done_res, done_res);
          mismatch_count++;
        end
        if (read_data !== exp_res.read_data) begin
          $error("read_data: expected %h, got %h", exp_res.read_data, read_data);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_end;
    sit_pkg::sit_result_t idle_res;
    sit_pkg::sit_result_t start_res;
    idle_res  = mk_res(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    start_res = mk_res(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);

    add_row(mk_tick(1'b1), 1, 1'b1, idle_res);
    add_row(mk_start(1'b1, 11'h7FF, 4'd0, '1), 1, 1'b1,
            mk_res(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, '0));
    add_row(mk_start(1'b0, 11'h000, 4'd1, 64'h0000_0000_0000_00A5), 1, 1'b1, start_res);
    add_row(mk_start(1'b1, 11'h123, 4'd2, '1), 1, 1'b1, start_res);
    add_row(mk_tick(1'b1), 24, 1'b0, '0);
    add_row(mk_tick(1'b0), 1, 1'b1, idle_res);
    // oversized count on a read, all ones sampled
    add_row(mk_start(1'b1, 11'h7FF, 4'd15, '0), 1, 1'b1, start_res);
    add_row(mk_start(1'b0, 11'h000, 4'd3, '0), 1, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk_tick(1'b1), 79, 1'b0, '0);
    add_row(mk_tick(1'b1), 1, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, '1));
    add_row(mk_start(1'b0, 11'h555, 4'd4, '1), 1, 1'b0, '0);
    add_row(mk_tick(1'b0), 48, 1'b0, '0);
    add_row(mk_start(1'b0, 11'h2AA, 4'd8, 64'h8000_0000_0000_0001), 1, 1'b0, '0);
    add_row(mk_tick(1'b0), 80, 1'b0, '0);
    add_row(mk_start(1'b1, 11'h001, 4'd9, '1), 1, 1'b0, '0);
    add_row(mk_tick(1'b0), 80, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      for (int unsigned n = 0; n < stim_rows[i].reps; n++)
        send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_end = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_end) run_transfer();
      // sender holds off until every result is back
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && slot_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> spi_instruction_transfer_core.f
rtl/core/sit_pkg.sv
rtl/core/sit_in_stage.sv
rtl/core/sit_engine.sv
rtl/core/sit_out_stage.sv
rtl/core/spi_instruction_transfer_core.sv
test/spi_instruction_transfer_core_test.sv
